// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the sector cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check an implication on every rising edge outside reset.
`define SCC_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the sector cache clock replacement block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int SECTOR_W    = 32;
    localparam int FUNC_W      = 2;
    localparam int SLOT_OUT_W  = 6;
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

    // Function codes on the input channel
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    // Classified operation passed from front to back
    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SECTOR_W-1:0] sector;
    } req_t;

endpackage

// ===== hw/rtl/scc_front.sv =====
// ----------------------------------------------------------------------------
// scc_front
// Accepts input words, classifies the function code, drops unused codes and
// queues requests for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [scc_pkg::FUNC_W-1:0]      s_func,
    input  logic [scc_pkg::SECTOR_W-1:0]    s_sector,
    output logic                            q_valid,
    input  logic                            q_ready,
    output scc_pkg::req_t                   q_req
);
    import scc_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    req_t           q_mem_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    req_t           req_in;
    logic           keep;
    logic           push;
    logic           pop;

    // Classify the function code
    always_comb begin
        keep          = 1'b1;
        req_in.op     = OP_READ;
        req_in.sector = s_sector;
        unique case (s_func)
            FUNC_READ:  req_in.op = OP_READ;
            FUNC_WRITE: req_in.op = OP_WRITE;
            FUNC_FLUSH: req_in.op = OP_FLUSH;
            default:    keep = 1'b0;
        endcase
    end

    // Queue handshake
    assign s_ready = (cnt_reg != QCW'(QDEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_req   = q_mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= req_in;
        end
    end

    `SCC_ASSERT(a_q_fill, aclk, aresetn, cnt_reg <= QCW'(QDEPTH), "queue overfilled")

endmodule

// ===== hw/rtl/scc_back.sv =====
// ----------------------------------------------------------------------------
// scc_back
// Tag cells, policy bits and clock hand. Looks up accesses, picks victims,
// installs sectors and walks the dirty slots on a flush.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scc_back #(
    parameter int SLOTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  scc_pkg::req_t                   q_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [scc_pkg::SLOT_OUT_W-1:0]  m_slot,
    output logic                            m_fetch_needed,
    output logic                            m_writeback_valid,
    output logic [scc_pkg::SECTOR_W-1:0]    m_writeback_sector,
    output logic                            m_last
);
    import scc_pkg::*;

    localparam int SW = $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_FLUSH
    } state_t;

    state_t                 state_reg;
    op_t                    op_reg;
    logic [SECTOR_W-1:0]    sector_reg;
    logic [SLOTS-1:0]       match_reg;
    logic [SLOTS-1:0]       pend_reg;
    logic [RES_CNT_W-1:0]   cnt_reg;
    logic [SW-1:0]          hand_reg;
    logic [SLOTS-1:0]       valid_reg;
    logic [SLOTS-1:0]       dirty_reg;
    logic [SLOTS-1:0]       ref_reg;
    logic [SECTOR_W-1:0]    tag_reg [SLOTS];

    logic                   m_valid_reg;
    logic                   m_hit_reg;
    logic [SLOT_OUT_W-1:0]  m_slot_reg;
    logic                   m_fetch_reg;
    logic                   m_wbv_reg;
    logic [SECTOR_W-1:0]    m_wbs_reg;
    logic                   m_last_reg;

    logic                   out_free;
    logic                   out_load;
    logic [SLOTS-1:0]       match_cmp;
    logic [SLOTS-1:0]       hit_oh;
    logic [SW-1:0]          hit_idx;
    logic                   hit_any;
    logic                   all_set;
    logic [SLOTS-1:0]       clear_vec;
    logic [SLOTS-1:0]       ge_mask;
    logic [SLOTS-1:0]       from_hand;
    logic [SLOTS-1:0]       vic_oh;
    logic [SW-1:0]          vic_idx;
    logic [SLOTS-1:0]       vic_bit;
    logic                   vic_wb;
    logic [SLOTS-1:0]       fl_oh;
    logic [SW-1:0]          fl_idx;
    logic [SLOTS-1:0]       fl_rest;
    logic                   fl_last;
    logic [SW-1:0]          rd_idx;
    logic [SECTOR_W-1:0]    rd_tag;
    logic                   chk_hit;
    logic                   hit_clean;
    logic                   chk_mid;
    logic                   flush_word;

    // Isolate the lowest set bit
    function automatic logic [SLOTS-1:0] lowest(input logic [SLOTS-1:0] x);
        return x & (~x + 1'b1);
    endfunction

    // Encode a one-hot vector into a slot index
    function automatic logic [SW-1:0] encode(input logic [SLOTS-1:0] oh);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (oh[i]) begin
                idx = idx | SW'(i);
            end
        end
        return idx;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE);

    // Load a new result word when one is ready and the register is free
    assign out_load = out_free && ((state_reg == S_APPLY) ||
                                   ((state_reg == S_FLUSH) && (pend_reg != '0)));

    // Compare the queued sector against every valid tag cell
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_cmp[i] = valid_reg[i] && (tag_reg[i] == q_req.sector);
            ge_mask[i]   = (SW'(i) >= hand_reg);
        end
    end

    // Resolve the hit, lowest matching slot first
    assign hit_oh  = lowest(match_reg);
    assign hit_idx = encode(hit_oh);
    assign hit_any = |match_reg;

    // Search from the hand for a clear reference bit, wrapping once
    assign all_set   = &ref_reg;
    assign clear_vec = ~ref_reg;
    assign from_hand = clear_vec & ge_mask;
    assign vic_oh    = (|from_hand) ? lowest(from_hand) : lowest(clear_vec);
    assign vic_idx   = all_set ? '0 : encode(vic_oh);
    assign vic_bit   = SLOTS'(1) << vic_idx;
    assign vic_wb    = valid_reg[vic_idx] && dirty_reg[vic_idx];

    // Pick the next dirty slot of a flush
    assign fl_oh   = lowest(pend_reg);
    assign fl_idx  = encode(fl_oh);
    assign fl_rest = pend_reg & ~fl_oh;
    assign fl_last = (fl_rest == '0) || (cnt_reg == RES_CNT_W'(MAX_RESULTS - 1));

    // Read one tag cell for a write-back
    assign rd_idx = (state_reg == S_FLUSH) ? fl_idx : vic_idx;
    assign rd_tag = tag_reg[rd_idx];

    // Sequence lookups, installs and flush walks; hold the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            ref_reg     <= '0;
            hand_reg    <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        op_reg     <= q_req.op;
                        sector_reg <= q_req.sector;
                        match_reg  <= match_cmp;
                        pend_reg   <= valid_reg & dirty_reg;
                        cnt_reg    <= '0;
                        state_reg  <= (q_req.op == OP_FLUSH) ? S_FLUSH : S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (out_free) begin
                        m_last_reg  <= 1'b1;
                        if (hit_any) begin
                            ref_reg[hit_idx]   <= 1'b1;
                            dirty_reg[hit_idx] <= dirty_reg[hit_idx] || (op_reg == OP_WRITE);
                            m_hit_reg          <= 1'b1;
                            m_slot_reg         <= SLOT_OUT_W'(hit_idx);
                            m_fetch_reg        <= 1'b0;
                            m_wbv_reg          <= 1'b0;
                            m_wbs_reg          <= '0;
                        end else begin
                            ref_reg            <= all_set ? vic_bit : (ref_reg | vic_bit);
                            hand_reg           <= vic_idx;
                            tag_reg[vic_idx]   <= sector_reg;
                            valid_reg[vic_idx] <= 1'b1;
                            dirty_reg[vic_idx] <= (op_reg == OP_WRITE);
                            m_hit_reg          <= 1'b0;
                            m_slot_reg         <= SLOT_OUT_W'(vic_idx);
                            m_fetch_reg        <= (op_reg == OP_READ);
                            m_wbv_reg          <= vic_wb;
                            m_wbs_reg          <= vic_wb ? rd_tag : '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (pend_reg == '0) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        m_hit_reg   <= 1'b0;
                        m_slot_reg  <= SLOT_OUT_W'(fl_idx);
                        m_fetch_reg <= 1'b0;
                        m_wbv_reg   <= 1'b1;
                        m_wbs_reg   <= rd_tag;
                        m_last_reg  <= fl_last;
                        pend_reg    <= fl_rest;
                        cnt_reg     <= cnt_reg + 1'b1;
                        if (fl_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_hit              = m_hit_reg;
    assign m_slot             = m_slot_reg;
    assign m_fetch_needed     = m_fetch_reg;
    assign m_writeback_valid  = m_wbv_reg;
    assign m_writeback_sector = m_wbs_reg;
    assign m_last             = m_last_reg;

    // Terms for the result checks
    assign chk_hit    = m_valid_reg && m_hit_reg;
    assign hit_clean  = !m_wbv_reg && !m_fetch_reg;
    assign chk_mid    = m_valid_reg && !m_last_reg;
    assign flush_word = m_wbv_reg && !m_hit_reg && (state_reg == S_FLUSH);

    `SCC_ASSERT(a_hand_range, aclk, aresetn, int'(hand_reg) < SLOTS, "hand out of range")
    `SCC_ASSERT_IMP(a_hit_clean, aclk, aresetn, chk_hit, hit_clean, "hit with side work")
    `SCC_ASSERT_IMP(a_mid_flush, aclk, aresetn, chk_mid, flush_word, "mid word outside flush")

endmodule

// ===== hw/rtl/sector_cache_clock_replacement.sv =====
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement
// Tag and clock-replacement controller for a fully associative sector cache.
//
//   channel   ports                        carries
//   input     s_valid/s_ready, s_func,      one access or flush request
//             s_sector
//   result    m_valid/m_ready, m_hit,       one result per access, one per
//             m_slot, m_fetch_needed, ...   dirty slot on a flush
//
// An access is handled in two back-end steps: a pop with the parallel tag compare,
// then, once the result register is free, the hit resolve or clock search and install.
// A flush first snapshots the dirty slots, then walks them lowest first, one result each.
// The front queue holds two requests, so up to two input words are accepted while the
// back end works or the result register waits on m_ready.
// Reset clears valid, dirty and reference bits and the hand.
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement #(
    parameter int SLOTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [scc_pkg::FUNC_W-1:0]      s_func,
    input  logic [scc_pkg::SECTOR_W-1:0]    s_sector,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [scc_pkg::SLOT_OUT_W-1:0]  m_slot,
    output logic                            m_fetch_needed,
    output logic                            m_writeback_valid,
    output logic [scc_pkg::SECTOR_W-1:0]    m_writeback_sector,
    output logic                            m_last
);
    import scc_pkg::*;

    logic q_valid;
    logic q_ready;
    req_t q_req;

    // Accept and classify
    scc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_sector (s_sector),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    // Look up, replace and flush
    scc_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_req              (q_req),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit              (m_hit),
        .m_slot             (m_slot),
        .m_fetch_needed     (m_fetch_needed),
        .m_writeback_valid  (m_writeback_valid),
        .m_writeback_sector (m_writeback_sector),
        .m_last             (m_last)
    );

endmodule
